/* src/afcr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afcr_pkg
// Shared constants, types and the byte-wise CRC16-CCITT update for the
// converter frame receiver.
// ----------------------------------------------------------------------------
package afcr_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 24;
  localparam int unsigned CRC_W    = 16;
  localparam int unsigned POS_W    = 4;

  localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h1021;
  localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;

  // frame byte positions
  localparam logic [POS_W-1:0] POS_FIRST    = 4'd0;
  localparam logic [POS_W-1:0] POS_CRC_LAST = 4'd8;
  localparam logic [POS_W-1:0] POS_LAST     = 4'd11;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_PATTERN = 2'd1,
    ERR_CRC     = 2'd2
  } frame_err_e;

  typedef struct packed {
    logic        [WORD_W-1:0] status_word;
    logic signed [WORD_W-1:0] channel_a;
    logic signed [WORD_W-1:0] channel_b;
    logic        [CRC_W-1:0]  received_check;
    logic        [CRC_W-1:0]  computed_check;
    frame_err_e               frame_error;
  } frame_result_t;

  // one byte into the crc, msb first, no reflection
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0]  crc,
                                                 input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* src/afcr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afcr_if
// Valid/ready channels of the frame receiver: the byte stream in and the
// decoded frame out.
// ----------------------------------------------------------------------------
interface afcr_in_if;
  logic                          valid;
  logic                          ready;
  logic [afcr_pkg::BYTE_W-1:0]   rx_byte;
  logic                          frame_start;

  modport source (output valid, rx_byte, frame_start, input ready);
  modport sink   (input valid, rx_byte, frame_start, output ready);
endinterface

interface afcr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [afcr_pkg::WORD_W-1:0]   status_word;
  logic signed [afcr_pkg::WORD_W-1:0]   channel_a;
  logic signed [afcr_pkg::WORD_W-1:0]   channel_b;
  logic        [afcr_pkg::CRC_W-1:0]    received_check;
  logic        [afcr_pkg::CRC_W-1:0]    computed_check;
  logic        [1:0]                    frame_error;

  modport source (output valid, status_word, channel_a, channel_b, received_check,
                  computed_check, frame_error, input ready);
  modport sink   (input valid, status_word, channel_a, channel_b, received_check,
                  computed_check, frame_error, output ready);
endinterface

/* src/afcr_assembler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afcr_assembler
// Per-byte frame state: position, running crc, pattern flags and the word
// shift registers. Flags a finished frame together with its decoded result.
// ----------------------------------------------------------------------------
module afcr_assembler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          byte_valid_i,
  input  logic [afcr_pkg::BYTE_W-1:0]   rx_byte_i,
  input  logic                          frame_start_i,
  output logic                          frame_done_o,
  output afcr_pkg::frame_result_t       result_o
);
  import afcr_pkg::*;

  logic [POS_W-1:0]  pos_q, pos_d, pos_base;
  logic [CRC_W-1:0]  crc_q, crc_d, crc_base;
  logic              zero_q, zero_d, zero_next;
  logic              ones_q, ones_d, ones_next;
  logic [WORD_W-1:0] status_q, status_d;
  logic [WORD_W-1:0] samp_a_q, samp_a_d;
  logic [WORD_W-1:0] samp_b_q, samp_b_d;
  logic [CRC_W-1:0]  check_q, check_d;
  logic              last_byte;

  // a start mark behaves as if the frame state had just been cleared
  assign pos_base  = frame_start_i ? POS_FIRST : pos_q;
  assign crc_base  = frame_start_i ? CRC_INIT  : crc_q;
  assign zero_next = (frame_start_i | zero_q) & (rx_byte_i == BYTE_ZERO);
  assign ones_next = (frame_start_i | ones_q) & (rx_byte_i == BYTE_ONES);
  assign last_byte = (pos_base >= POS_LAST);

  always_comb begin
    pos_d    = pos_q;
    crc_d    = crc_q;
    zero_d   = zero_q;
    ones_d   = ones_q;
    status_d = status_q;
    samp_a_d = samp_a_q;
    samp_b_d = samp_b_q;
    check_d  = check_q;
    if (byte_valid_i) begin
      if (last_byte) begin
        pos_d  = POS_FIRST;
        crc_d  = CRC_INIT;
        zero_d = 1'b1;
        ones_d = 1'b1;
      end else begin
        pos_d  = pos_base + 4'd1;
        crc_d  = (pos_base <= POS_CRC_LAST) ? crc_feed(crc_base, rx_byte_i) : crc_base;
        zero_d = zero_next;
        ones_d = ones_next;
      end
      case (pos_base) inside
        4'd0, 4'd1, 4'd2: status_d = {status_q[WORD_W-BYTE_W-1:0], rx_byte_i};
        4'd3, 4'd4, 4'd5: samp_a_d = {samp_a_q[WORD_W-BYTE_W-1:0], rx_byte_i};
        4'd6, 4'd7, 4'd8: samp_b_d = {samp_b_q[WORD_W-BYTE_W-1:0], rx_byte_i};
        4'd9, 4'd10:      check_d  = {check_q[CRC_W-BYTE_W-1:0], rx_byte_i};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_FIRST;
      crc_q  <= CRC_INIT;
      zero_q <= 1'b1;
      ones_q <= 1'b1;
    end else begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      zero_q <= zero_d;
      ones_q <= ones_d;
    end
  end

  // every word is fully shifted in before a frame completes
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    samp_a_q <= samp_a_d;
    samp_b_q <= samp_b_d;
    check_q  <= check_d;
  end

  assign frame_done_o = byte_valid_i & last_byte;

  always_comb begin
    result_o.status_word    = status_q;
    result_o.channel_a      = samp_a_q;
    result_o.channel_b      = samp_b_q;
    result_o.received_check = check_q;
    result_o.computed_check = crc_q;
    if (zero_next || ones_next) begin
      result_o.frame_error = ERR_PATTERN;
    end else if (check_q != crc_q) begin
      result_o.frame_error = ERR_CRC;
    end else begin
      result_o.frame_error = ERR_NONE;
    end
  end

endmodule

/* src/adc_frame_crc_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_frame_crc_receiver
// Receives 12-byte converter frames, checks the CRC16-CCITT and the all-zero
// and all-ones patterns, and returns status, both samples and an error code.
// ----------------------------------------------------------------------------
// throughput: one byte per cycle while the input is not stalled; a frame is twelve bytes
// latency: the result is valid the cycle after the twelfth byte is taken
// the output register holds one result; input stalls only while it is full
// and not being drained
// reset clears the byte position, crc, pattern flags and the output valid
module adc_frame_crc_receiver (
  input  logic       clk_i,
  input  logic       rst_ni,
  afcr_in_if.sink    in_bus_i,
  afcr_out_if.source out_bus_o
);
  import afcr_pkg::*;

  logic          in_accept;
  logic          frame_done;
  frame_result_t frame_res;
  frame_result_t res_q;
  logic          out_valid_q, out_valid_d;

  assign in_bus_i.ready = !out_valid_q || out_bus_o.ready;
  assign in_accept      = in_bus_i.valid && in_bus_i.ready;

  afcr_assembler u_assembler (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_valid_i  (in_accept),
    .rx_byte_i     (in_bus_i.rx_byte),
    .frame_start_i (in_bus_i.frame_start),
    .frame_done_o  (frame_done),
    .result_o      (frame_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (frame_done) begin
      out_valid_d = 1'b1;
    end else if (out_bus_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_done) begin
      res_q <= frame_res;
    end
  end

  assign out_bus_o.valid          = out_valid_q;
  assign out_bus_o.status_word    = res_q.status_word;
  assign out_bus_o.channel_a      = res_q.channel_a;
  assign out_bus_o.channel_b      = res_q.channel_b;
  assign out_bus_o.received_check = res_q.received_check;
  assign out_bus_o.computed_check = res_q.computed_check;
  assign out_bus_o.frame_error    = res_q.frame_error;

  // a new result only follows an accepted byte
  a_result_from_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_accept))
    else $error("result appeared without an accepted byte");

  // crc error code agrees with the reported check values
  a_crc_err_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.frame_error == ERR_CRC)
      |-> (res_q.received_check != res_q.computed_check))
    else $error("crc error flagged on matching check");

  a_good_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.frame_error == ERR_NONE)
      |-> (res_q.received_check == res_q.computed_check))
    else $error("good frame with mismatching check");

  // a pending result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_bus_o.ready) |-> !frame_done)
    else $error("pending result overwritten");

endmodule

/* bench/afcr_frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afcr_frame_checker
// Watches the byte and result channels of the frame receiver. It keeps its own
// copy of the frame state, predicts the decoded frame for every twelfth byte
// and compares each returned frame field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module afcr_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  afcr_in_if          in_mon_i,
  afcr_out_if         out_mon_i,
  output int unsigned fail_count_o,
  output int unsigned frames_pending_o
);
  import afcr_pkg::*;

  localparam logic [POS_W-1:0] POS_STATUS_END = 4'd2;
  localparam logic [POS_W-1:0] POS_CHAN_A_END = 4'd5;
  localparam logic [POS_W-1:0] POS_CHECK_END  = 4'd10;
  localparam int unsigned      REPORT_LIMIT   = 10;

  logic [POS_W-1:0]  byte_pos_q;
  logic [CRC_W-1:0]  crc_q;
  logic              only_zero_q;
  logic              only_ones_q;
  logic [WORD_W-1:0] status_q;
  logic [WORD_W-1:0] chan_a_q;
  logic [WORD_W-1:0] chan_b_q;
  logic [CRC_W-1:0]  check_q;

  frame_result_t     expected_frames[$];
  int unsigned       fail_cnt = 0;
  int unsigned       pending_cnt = 0;

  assign fail_count_o     = fail_cnt;
  assign frames_pending_o = pending_cnt;

  // bit-serial form of the ccitt update, msb of the byte first
  function automatic logic [CRC_W-1:0] crc_next(input logic [CRC_W-1:0]  crc,
                                                input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    logic             fb;
    c = crc;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      fb = c[CRC_W-1] ^ data[i];
      c  = {c[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
    end
    return c;
  endfunction

  task automatic restart_frame();
    byte_pos_q  = POS_FIRST;
    crc_q       = CRC_INIT;
    only_zero_q = 1'b1;
    only_ones_q = 1'b1;
    status_q    = '0;
    chan_a_q    = '0;
    chan_b_q    = '0;
    check_q     = '0;
  endtask

  task automatic absorb_byte(input logic [BYTE_W-1:0] data, input logic start);
    logic [POS_W-1:0] pos;
    frame_result_t    res;
    if (start) begin
      restart_frame();
    end
    pos = byte_pos_q;
    if (data != BYTE_ZERO) only_zero_q = 1'b0;
    if (data != BYTE_ONES) only_ones_q = 1'b0;
    if (pos <= POS_CRC_LAST) crc_q = crc_next(crc_q, data);
    if (pos <= POS_STATUS_END) begin
      status_q = {status_q[WORD_W-BYTE_W-1:0], data};
    end else if (pos <= POS_CHAN_A_END) begin
      chan_a_q = {chan_a_q[WORD_W-BYTE_W-1:0], data};
    end else if (pos <= POS_CRC_LAST) begin
      chan_b_q = {chan_b_q[WORD_W-BYTE_W-1:0], data};
    end else if (pos <= POS_CHECK_END) begin
      check_q = {check_q[CRC_W-BYTE_W-1:0], data};
    end
    if (pos < POS_LAST) begin
      byte_pos_q = pos + 1'b1;
    end else begin
      res.status_word    = status_q;
      res.channel_a      = chan_a_q;
      res.channel_b      = chan_b_q;
      res.received_check = check_q;
      res.computed_check = crc_q;
      // pattern error wins over a crc mismatch
      if (only_zero_q || only_ones_q) begin
        res.frame_error = ERR_PATTERN;
      end else if (check_q != crc_q) begin
        res.frame_error = ERR_CRC;
      end else begin
        res.frame_error = ERR_NONE;
      end
      expected_frames.push_back(res);
      restart_frame();
    end
  endtask

  task automatic flag_field(input string             field,
                            input logic [WORD_W-1:0] exp_v,
                            input logic [WORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      if (fail_cnt < REPORT_LIMIT) begin
        $display("%0t: frame mismatch on %s: expected %h, got %h", $realtime, field,
                 exp_v, act_v);
      end
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : frame_check
    frame_result_t exp_r;
    if (!rst_ni) begin
      restart_frame();
      expected_frames.delete();
      pending_cnt = 0;
    end else begin
      if (in_mon_i.valid && in_mon_i.ready) begin
        absorb_byte(in_mon_i.rx_byte, in_mon_i.frame_start);
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_frames.size() == 0) begin
          if (fail_cnt < REPORT_LIMIT) begin
            $display("%0t: frame result with none expected: status %h", $realtime,
                     out_mon_i.status_word);
          end
          fail_cnt++;
        end else begin
          exp_r = expected_frames.pop_front();
          flag_field("status_word", exp_r.status_word, out_mon_i.status_word);
          flag_field("channel_a", exp_r.channel_a, out_mon_i.channel_a);
          flag_field("channel_b", exp_r.channel_b, out_mon_i.channel_b);
          flag_field("received_check", WORD_W'(exp_r.received_check),
                     WORD_W'(out_mon_i.received_check));
          flag_field("computed_check", WORD_W'(exp_r.computed_check),
                     WORD_W'(out_mon_i.computed_check));
          flag_field("frame_error", WORD_W'(exp_r.frame_error),
                     WORD_W'(out_mon_i.frame_error));
        end
      end
      pending_cnt = expected_frames.size();
    end
  end

endmodule

/* bench/tb_adc_frame_crc_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adc_frame_crc_receiver
// Drives converter frames into the receiver: a few hand-built frames, then
// random good, corrupted, pattern, cut-short and noise frames under several
// idle and stall mixes. The frame checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_adc_frame_crc_receiver;
  import afcr_pkg::*;

  localparam int unsigned CLK_HALF      = 2;
  localparam int unsigned RESET_CYCLES  = 11;
  localparam int unsigned FRAME_LEN     = 12;
  localparam int unsigned CRC_BYTES     = 9;
  localparam int unsigned RANDOM_BYTES  = 1400;
  localparam int unsigned PHASE_COUNT   = 4;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef enum int {
    FR_GOOD,
    FR_BAD_CRC,
    FR_ZEROS,
    FR_ONES,
    FR_NEAR_ZEROS,
    FR_NEAR_ONES,
    FR_CUT,
    FR_NOISE
  } frame_kind_e;

  typedef logic [BYTE_W-1:0] frame_bytes_t [FRAME_LEN];

  logic        clk_i;
  logic        rst_ni;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned bytes_sent     = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned fail_count;
  int unsigned frames_pending;
  logic        need_start     = 1'b0;

  afcr_in_if  in_bus ();
  afcr_out_if out_bus ();

  adc_frame_crc_receiver i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_bus_i  (in_bus),
    .out_bus_o (out_bus)
  );

  afcr_frame_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon_i         (in_bus),
    .out_mon_i        (out_bus),
    .fail_count_o     (fail_count),
    .frames_pending_o (frames_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  // result side back-pressure
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  function automatic logic [WORD_W-1:0] pick_sample();
    case ($urandom_range(5))
      0:       return 24'h800000;
      1:       return 24'h7FFFFF;
      2:       return '0;
      3:       return 24'hFFFFFF;
      default: return WORD_W'($urandom);
    endcase
  endfunction

  function automatic frame_bytes_t build_frame(input logic [WORD_W-1:0] st,
                                               input logic [WORD_W-1:0] ca,
                                               input logic [WORD_W-1:0] cb,
                                               input logic [BYTE_W-1:0] tail);
    frame_bytes_t        fb;
    logic [CRC_W-1:0]    crc;
    logic [3*WORD_W-1:0] body;
    body = {st, ca, cb};
    crc  = CRC_INIT;
    for (int i = 0; i < CRC_BYTES; i++) begin
      fb[i] = body[3*WORD_W-1-BYTE_W*i -: BYTE_W];
      crc   = crc_feed(crc, fb[i]);
    end
    fb[9]  = crc[CRC_W-1:BYTE_W];
    fb[10] = crc[BYTE_W-1:0];
    fb[11] = tail;
    return fb;
  endfunction

  // one request on the byte channel, with random idle cycles carrying junk
  task automatic send_byte(input logic [BYTE_W-1:0] data, input logic start);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid       <= 1'b0;
      in_bus.rx_byte     <= BYTE_W'($urandom);
      in_bus.frame_start <= 1'($urandom);
      @(negedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.rx_byte     <= data;
    in_bus.frame_start <= start;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (frames_pending != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random_frame();
    frame_bytes_t fb;
    frame_kind_e  kind;
    int unsigned  pick;
    int unsigned  len;
    int unsigned  spot;
    logic         start;
    pick = $urandom_range(99);
    if (pick < 50)      kind = FR_GOOD;
    else if (pick < 62) kind = FR_BAD_CRC;
    else if (pick < 67) kind = FR_ZEROS;
    else if (pick < 72) kind = FR_ONES;
    else if (pick < 77) kind = FR_NEAR_ZEROS;
    else if (pick < 82) kind = FR_NEAR_ONES;
    else if (pick < 92) kind = FR_CUT;
    else                kind = FR_NOISE;
    // an aligned frame may go without its start mark
    start = need_start || ($urandom_range(3) != 0);
    len   = FRAME_LEN;
    spot  = ($urandom_range(1) != 0) ? FRAME_LEN - 1 : $urandom_range(FRAME_LEN - 1);
    case (kind)
      FR_ZEROS, FR_NEAR_ZEROS: begin
        foreach (fb[i]) fb[i] = BYTE_ZERO;
        if (kind == FR_NEAR_ZEROS) fb[spot] = BYTE_W'($urandom_range(255, 1));
      end
      FR_ONES, FR_NEAR_ONES: begin
        foreach (fb[i]) fb[i] = BYTE_ONES;
        if (kind == FR_NEAR_ONES) fb[spot] = BYTE_W'($urandom_range(254));
      end
      FR_NOISE: begin
        len = $urandom_range(20, 1);
        for (int i = 0; i < len; i++) begin
          send_byte(BYTE_W'($urandom), ($urandom_range(7) == 0));
        end
      end
      default: begin
        fb = build_frame(($urandom_range(1) != 0) ? pick_sample() : WORD_W'($urandom),
                         pick_sample(), pick_sample(), BYTE_W'($urandom));
        if (kind == FR_BAD_CRC) begin
          spot     = $urandom_range(10);
          fb[spot] = fb[spot] ^ BYTE_W'(1 << $urandom_range(BYTE_W - 1));
        end
        if (kind == FR_CUT) len = $urandom_range(FRAME_LEN - 1, 1);
      end
    endcase
    if (kind != FR_NOISE) begin
      for (int i = 0; i < len; i++) begin
        send_byte(fb[i], (i == 0) && start);
      end
    end
    need_start = (kind == FR_NOISE) || (kind == FR_CUT);
  endtask

  initial begin
    frame_bytes_t fb;
    int unsigned  goal;
    rst_ni             <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.rx_byte     <= '0;
    in_bus.frame_start <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // first frame right after reset carries no start mark, samples at the extremes
    fb = build_frame(24'hFFFFFF, 24'h800000, 24'h7FFFFF, BYTE_ZERO);
    foreach (fb[i]) send_byte(fb[i], 1'b0);
    // a cut frame dropped by a start mark, then an all-ones frame
    send_byte(BYTE_ZERO, 1'b1);
    send_byte(BYTE_ONES, 1'b0);
    send_byte(8'h5A, 1'b0);
    for (int i = 0; i < FRAME_LEN; i++) send_byte(BYTE_ONES, (i == 0));
    wait_drained();

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 48; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 48; end
        default: begin src_idle_pct = 29; sink_stall_pct = 29; end
      endcase
      goal = bytes_sent + RANDOM_BYTES / PHASE_COUNT;
      while (bytes_sent < goal) send_random_frame();
      // hold the byte stream until every frame has come back
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && frames_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
